@@ hdl/ffba_pkg.sv @@
// ----------------------------------------------------------------------------
// ffba_pkg
// Shared types and constants of the first-fit block allocator: command and
// status codes, the scan token that travels down the cell chain, and the
// append write broadcast to the cells.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int unsigned MaxBlocksDef   = 64;
  localparam int unsigned HeaderBytesDef = 32;
  localparam int unsigned AddrW          = 32;
  localparam int unsigned CfgIdxW        = 1;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_REALLOC = 2'd2
  } cmd_e;

  typedef enum logic [2:0] {
    STAT_OK      = 3'd0,
    STAT_ZERO    = 3'd1,
    STAT_LIMIT   = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_UNKNOWN = 3'd4
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_HEAP_BASE  = 1'b0,
    CFG_HEAP_LIMIT = 1'b1
  } cfg_idx_e;

  // scan kinds: first free block large enough (mark used), pointer match
  // (look only), pointer match (mark free)
  typedef enum logic [1:0] {
    OP_FIT   = 2'd0,
    OP_FIND  = 2'd1,
    OP_FREE  = 2'd2
  } tok_op_e;

  typedef enum logic [2:0] {
    S_IDLE  = 3'd0,
    S_FIND  = 3'd1,
    S_FIT   = 3'd2,
    S_FREE  = 3'd3,
    S_RFREE = 3'd4,
    S_EMIT  = 3'd5
  } state_e;

  typedef struct packed {
    logic             vld;
    tok_op_e          op;
    logic [AddrW-1:0] key;
    logic             hit;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] bytes;
  } tok_t;

  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] start;
    logic [AddrW-1:0] bytes;
  } cell_wr_t;

endpackage

@@ hdl/ffba_req_if.sv @@
// ----------------------------------------------------------------------------
// ffba_req_if
// Request channel of the allocator: command, size and user pointer.
// ----------------------------------------------------------------------------
interface ffba_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [31:0] request_size;
  logic [31:0] user_pointer;

  modport source (output valid, output cmd, output request_size,
                  output user_pointer, input ready);
  modport sink   (input valid, input cmd, input request_size,
                  input user_pointer, output ready);
endinterface

@@ hdl/ffba_rsp_if.sv @@
// ----------------------------------------------------------------------------
// ffba_rsp_if
// Result channel of the allocator: returned pointer and status.
// ----------------------------------------------------------------------------
interface ffba_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_pointer;
  logic [2:0]  status;

  modport source (output valid, output result_pointer, output status,
                  input ready);
  modport sink   (input valid, input result_pointer, input status,
                  output ready);
endinterface

@@ hdl/first_fit_block_allocator.sv @@
// Scans: allocate and free take one scan of the cell chain, reallocate up to
// three (find owner, fit, free owner). A request needing no scan (zero size,
// null free) goes straight to the result stage. One request at a time.
// Reset clears the block count, sets heap end and heap base to 0 and the
// limit to all ones; entry contents are undefined until appended.
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// First-fit heap block allocator built as a chain of table cells with a
// sequencing controller, heap end and configuration registers.
// ----------------------------------------------------------------------------
module first_fit_block_allocator #(
  parameter int unsigned MAX_BLOCKS   = ffba_pkg::MaxBlocksDef,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  ffba_req_if.sink                      req_i,
  ffba_rsp_if.source                    rsp_o,
  input  logic                          cfg_we_i,
  input  logic [ffba_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ffba_pkg::AddrW-1:0]    cfg_wdata_i
);

  localparam int unsigned CntW = $clog2(MAX_BLOCKS + 1);
  localparam int unsigned AW   = ffba_pkg::AddrW;

  ffba_pkg::state_e   state_q, state_d;
  logic               own_q, own_d;
  logic [AW-1:0]      size_q, size_d;
  logic [AW-1:0]      ptr_q, ptr_d;
  logic [AW-1:0]      res_ptr_q, res_ptr_d;
  ffba_pkg::status_e  res_st_q, res_st_d;
  ffba_pkg::tok_t     inj_q, inj_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic [AW-1:0]      heap_end_q, heap_end_d;
  logic [AW-1:0]      base_q, base_d;
  logic [AW-1:0]      limit_q, limit_d;
  logic               out_vld_q, out_vld_d;
  logic [AW-1:0]      out_ptr_q, out_ptr_d;
  ffba_pkg::status_e  out_st_q, out_st_d;

  ffba_pkg::tok_t     tok [MAX_BLOCKS+1];
  logic [MAX_BLOCKS-1:0] tok_vld;
  ffba_pkg::tok_t     end_tok;
  logic               app_en;
  logic               ld_out;
  logic [AW+1:0]      new_end;
  logic               full;
  logic               over;

  assign tok[0]  = inj_q;
  assign end_tok = tok[MAX_BLOCKS];

  for (genvar k = 0; k < MAX_BLOCKS; k++) begin : g_cell
    ffba_pkg::cell_wr_t wr;
    assign wr.en    = app_en && (cnt_q == CntW'(k));
    assign wr.start = heap_end_q;
    assign wr.bytes = size_q;

    ffba_cell #(
      .IDX          (k),
      .CNT_W        (CntW),
      .HEADER_BYTES (HEADER_BYTES)
    ) u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .cnt_i  (cnt_q),
      .wr_i   (wr),
      .tok_i  (tok[k]),
      .tok_o  (tok[k+1])
    );

    assign tok_vld[k] = tok[k+1].vld;
  end

  assign new_end = {2'b00, heap_end_q} + (AW+2)'(HEADER_BYTES) + {2'b00, size_q};
  assign full    = cnt_q == CntW'(MAX_BLOCKS);
  assign over    = new_end > {2'b00, limit_q};

  assign req_i.ready = state_q == ffba_pkg::S_IDLE;

  always_comb begin
    state_d    = state_q;
    own_d      = own_q;
    size_d     = size_q;
    ptr_d      = ptr_q;
    res_ptr_d  = res_ptr_q;
    res_st_d   = res_st_q;
    inj_d      = '0;
    cnt_d      = cnt_q;
    heap_end_d = heap_end_q;
    base_d     = base_q;
    limit_d    = limit_q;
    app_en     = 1'b0;
    ld_out     = 1'b0;

    case (state_q)
      ffba_pkg::S_IDLE: begin
        if (req_i.valid) begin
          size_d    = req_i.request_size;
          ptr_d     = req_i.user_pointer;
          own_d     = 1'b0;
          res_ptr_d = '0;
          res_st_d  = ffba_pkg::STAT_OK;
          state_d   = ffba_pkg::S_EMIT;
          case (ffba_pkg::cmd_e'(req_i.cmd))
            ffba_pkg::CMD_ALLOC: begin
              if (req_i.request_size == '0) begin
                res_st_d = ffba_pkg::STAT_ZERO;
              end else begin
                inj_d.vld = 1'b1;
                inj_d.op  = ffba_pkg::OP_FIT;
                inj_d.key = req_i.request_size;
                state_d   = ffba_pkg::S_FIT;
              end
            end
            ffba_pkg::CMD_FREE: begin
              if (req_i.user_pointer != '0) begin
                inj_d.vld = 1'b1;
                inj_d.op  = ffba_pkg::OP_FREE;
                inj_d.key = req_i.user_pointer;
                state_d   = ffba_pkg::S_FREE;
              end
            end
            ffba_pkg::CMD_REALLOC: begin
              if (req_i.request_size == '0) begin
                res_st_d = ffba_pkg::STAT_ZERO;
              end else if (req_i.user_pointer == '0) begin
                inj_d.vld = 1'b1;
                inj_d.op  = ffba_pkg::OP_FIT;
                inj_d.key = req_i.request_size;
                state_d   = ffba_pkg::S_FIT;
              end else begin
                inj_d.vld = 1'b1;
                inj_d.op  = ffba_pkg::OP_FIND;
                inj_d.key = req_i.user_pointer;
                state_d   = ffba_pkg::S_FIND;
              end
            end
            default: ;
          endcase
        end
      end
      ffba_pkg::S_FIND: begin
        if (end_tok.vld) begin
          if (!end_tok.hit) begin
            res_st_d = ffba_pkg::STAT_UNKNOWN;
            state_d  = ffba_pkg::S_EMIT;
          end else if (end_tok.bytes >= size_q) begin
            res_ptr_d = ptr_q;
            state_d   = ffba_pkg::S_EMIT;
          end else begin
            // owner too small: allocate anew, then free the owner if that succeeded
            own_d     = 1'b1;
            inj_d.vld = 1'b1;
            inj_d.op  = ffba_pkg::OP_FIT;
            inj_d.key = size_q;
            state_d   = ffba_pkg::S_FIT;
          end
        end
      end
      ffba_pkg::S_FIT: begin
        if (end_tok.vld) begin
          state_d = ffba_pkg::S_EMIT;
          if (end_tok.hit) begin
            res_ptr_d = end_tok.start + AW'(HEADER_BYTES);
          end else if (full) begin
            res_st_d = ffba_pkg::STAT_FULL;
          end else if (over) begin
            res_st_d = ffba_pkg::STAT_LIMIT;
          end else begin
            app_en     = 1'b1;
            res_ptr_d  = heap_end_q + AW'(HEADER_BYTES);
            cnt_d      = cnt_q + CntW'(1);
            heap_end_d = new_end[AW-1:0];
          end
          if (own_q && (end_tok.hit || (!full && !over))) begin
            inj_d.vld = 1'b1;
            inj_d.op  = ffba_pkg::OP_FREE;
            inj_d.key = ptr_q;
            state_d   = ffba_pkg::S_RFREE;
          end
        end
      end
      ffba_pkg::S_FREE: begin
        if (end_tok.vld) begin
          if (!end_tok.hit) begin
            res_st_d = ffba_pkg::STAT_UNKNOWN;
          end
          state_d = ffba_pkg::S_EMIT;
        end
      end
      ffba_pkg::S_RFREE: begin
        if (end_tok.vld) begin
          state_d = ffba_pkg::S_EMIT;
        end
      end
      ffba_pkg::S_EMIT: begin
        // hold the result until the output register frees up
        if (!out_vld_q || rsp_o.ready) begin
          ld_out  = 1'b1;
          state_d = ffba_pkg::S_IDLE;
        end
      end
      default: state_d = ffba_pkg::S_IDLE;
    endcase

    if (cfg_we_i) begin
      case (ffba_pkg::cfg_idx_e'(cfg_idx_i))
        ffba_pkg::CFG_HEAP_BASE: begin
          base_d = cfg_wdata_i;
          if (cnt_q == '0) begin
            heap_end_d = cfg_wdata_i;
          end
        end
        ffba_pkg::CFG_HEAP_LIMIT: limit_d = cfg_wdata_i;
        default: ;
      endcase
    end

    out_vld_d = out_vld_q;
    out_ptr_d = out_ptr_q;
    out_st_d  = out_st_q;
    if (ld_out) begin
      out_vld_d = 1'b1;
      out_ptr_d = res_ptr_q;
      out_st_d  = res_st_q;
    end else if (rsp_o.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ffba_pkg::S_IDLE;
      inj_q      <= '0;
      cnt_q      <= '0;
      heap_end_q <= '0;
      base_q     <= '0;
      limit_q    <= '1;
      out_vld_q  <= 1'b0;
      own_q      <= 1'b0;
    end else begin
      state_q    <= state_d;
      inj_q      <= inj_d;
      cnt_q      <= cnt_d;
      heap_end_q <= heap_end_d;
      base_q     <= base_d;
      limit_q    <= limit_d;
      out_vld_q  <= out_vld_d;
      own_q      <= own_d;
    end
  end

  always_ff @(posedge clk_i) begin
    size_q    <= size_d;
    ptr_q     <= ptr_d;
    res_ptr_q <= res_ptr_d;
    res_st_q  <= res_st_d;
    out_ptr_q <= out_ptr_d;
    out_st_q  <= out_st_d;
  end

  assign rsp_o.valid          = out_vld_q;
  assign rsp_o.result_pointer = out_ptr_q;
  assign rsp_o.status         = out_st_q;

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(MAX_BLOCKS))
    else $error("block count beyond table size");

  a_one_token: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({tok_vld, inj_q.vld}))
    else $error("more than one scan token in the chain");

  a_token_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    end_tok.vld |-> (state_q == ffba_pkg::S_FIND || state_q == ffba_pkg::S_FIT ||
                     state_q == ffba_pkg::S_FREE || state_q == ffba_pkg::S_RFREE))
    else $error("scan token left the chain outside a scan");

  a_heap_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(heap_end_q) |-> $past(app_en || (cfg_we_i && cnt_q == '0)))
    else $error("heap end moved without append or base write");

  a_cnt_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    app_en |=> cnt_q == $past(cnt_q) + CntW'(1))
    else $error("append did not advance the block count");

endmodule

@@ hdl/ffba_cell.sv @@
// ----------------------------------------------------------------------------
// ffba_cell
// One table entry of the allocator. Holds start, size and free mark of one
// heap block, tests the passing scan token against it and hands the token
// on to the next cell in the cycle after.
// ----------------------------------------------------------------------------
module ffba_cell #(
  parameter int unsigned IDX          = 0,
  parameter int unsigned CNT_W        = 7,
  parameter int unsigned HEADER_BYTES = ffba_pkg::HeaderBytesDef
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic [CNT_W-1:0]  cnt_i,
  input  ffba_pkg::cell_wr_t wr_i,
  input  ffba_pkg::tok_t    tok_i,
  output ffba_pkg::tok_t    tok_o
);

  logic [ffba_pkg::AddrW-1:0] start_q;
  logic [ffba_pkg::AddrW-1:0] bytes_q;
  logic                       free_q;
  ffba_pkg::tok_t             tok_q, tok_d;

  logic ent_vld;
  logic ptr_hit;
  logic fit_hit;
  logic take;

  assign ent_vld = cnt_i > CNT_W'(IDX);
  assign ptr_hit = (start_q + ffba_pkg::AddrW'(HEADER_BYTES)) == tok_i.key;
  assign fit_hit = free_q && (bytes_q >= tok_i.key);

  always_comb begin
    take = 1'b0;
    if (tok_i.vld && !tok_i.hit && ent_vld) begin
      case (tok_i.op)
        ffba_pkg::OP_FIT:  take = fit_hit;
        ffba_pkg::OP_FIND: take = ptr_hit;
        ffba_pkg::OP_FREE: take = ptr_hit;
        default:           take = 1'b0;
      endcase
    end
    tok_d = tok_i;
    if (take) begin
      tok_d.hit   = 1'b1;
      tok_d.start = start_q;
      tok_d.bytes = bytes_q;
    end
  end

  // entry contents carry no reset: only entries below the count are read
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      start_q <= wr_i.start;
      bytes_q <= wr_i.bytes;
      free_q  <= 1'b0;
    end else if (take) begin
      case (tok_i.op)
        ffba_pkg::OP_FIT:  free_q <= 1'b0;
        ffba_pkg::OP_FREE: free_q <= 1'b1;
        default:           free_q <= free_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tok_q <= '0;
    end else begin
      tok_q <= tok_d;
    end
  end

  assign tok_o = tok_q;

endmodule

@@ verif/testbench.sv @@
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for first_fit_block_allocator. Sends allocate, free and
// reallocate requests with random gaps and stalls, mirrors the heap table in
// the bench, and compares every returned pointer and status in order.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NumBlocks  = ffba_pkg::MaxBlocksDef;
  localparam logic [31:0] HdrBytes   = ffba_pkg::HeaderBytesDef;
  localparam int unsigned ScanCycles = NumBlocks + 2;
  localparam logic [1:0]  CmdUnused  = 2'd3;

  typedef struct packed {
    logic [31:0]       pointer;
    ffba_pkg::status_e status;
  } grant_t;

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  ffba_pkg::cfg_idx_e cfg_idx;
  logic [31:0]        cfg_wdata;

  ffba_req_if req_if();
  ffba_rsp_if rsp_if();

  first_fit_block_allocator #(
    .MAX_BLOCKS  (NumBlocks),
    .HEADER_BYTES(ffba_pkg::HeaderBytesDef)
  ) DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_i      (req_if),
    .rsp_o      (rsp_if),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_wdata_i(cfg_wdata)
  );

  always begin
    clk_i = 1'b0;
    #2;
    clk_i = 1'b1;
    #2;
  end

  // heap table as the allocator should hold it
  logic [31:0] tbl_start [NumBlocks];
  logic [31:0] tbl_bytes [NumBlocks];
  bit          tbl_free  [NumBlocks];
  int          tbl_count;
  logic [31:0] heap_end;
  logic [31:0] heap_base;
  logic [31:0] heap_limit;

  grant_t      grants_due [$];
  int unsigned fail_count;
  int unsigned request_count;
  int unsigned status_tally [8];

  int unsigned req_gap_max;
  int unsigned rsp_stall_max;
  int unsigned rsp_hold_cycles;
  bit          req_up;

  function automatic int owner_index(input logic [31:0] ptr);
    int i;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_start[i] + HdrBytes == ptr) return i;
    end
    return -1;
  endfunction

  // first fit over the table, else append at the heap end
  function automatic ffba_pkg::status_e take_block(input logic [31:0] size,
                                                   output logic [31:0] ptr);
    logic [33:0] grown;
    int          i;
    ptr = '0;
    if (size == '0) return ffba_pkg::STAT_ZERO;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_bytes[i] >= size) begin
        tbl_free[i] = 1'b0;
        ptr = tbl_start[i] + HdrBytes;
        return ffba_pkg::STAT_OK;
      end
    end
    if (tbl_count >= NumBlocks) return ffba_pkg::STAT_FULL;
    grown = {2'b00, heap_end} + {2'b00, HdrBytes} + {2'b00, size};
    if (grown > {2'b00, heap_limit}) return ffba_pkg::STAT_LIMIT;
    tbl_start[tbl_count] = heap_end;
    tbl_bytes[tbl_count] = size;
    tbl_free[tbl_count]  = 1'b0;
    ptr = heap_end + HdrBytes;
    tbl_count++;
    heap_end = grown[31:0];
    return ffba_pkg::STAT_OK;
  endfunction

  function automatic grant_t apply_request(input logic [1:0] cmd, input logic [31:0] size,
                                           input logic [31:0] ptr);
    grant_t      g;
    logic [31:0] got;
    int          owner;
    g.pointer = '0;
    g.status  = ffba_pkg::STAT_OK;
    got       = '0;
    case (cmd)
      ffba_pkg::CMD_ALLOC: begin
        g.status  = take_block(size, got);
        g.pointer = got;
      end
      ffba_pkg::CMD_FREE: begin
        if (ptr != '0) begin
          owner = owner_index(ptr);
          if (owner < 0) g.status = ffba_pkg::STAT_UNKNOWN;
          else tbl_free[owner] = 1'b1;
        end
      end
      ffba_pkg::CMD_REALLOC: begin
        if (size == '0) begin
          g.status = ffba_pkg::STAT_ZERO;
        end else if (ptr == '0) begin
          g.status  = take_block(size, got);
          g.pointer = got;
        end else begin
          owner = owner_index(ptr);
          if (owner < 0) begin
            g.status = ffba_pkg::STAT_UNKNOWN;
          end else if (tbl_bytes[owner] >= size) begin
            g.pointer = ptr;
          end else begin
            g.status  = take_block(size, got);
            g.pointer = got;
            // old block is released only when the move succeeded
            if (g.status == ffba_pkg::STAT_OK) tbl_free[owner] = 1'b1;
          end
        end
      end
      default: ;
    endcase
    return g;
  endfunction

  function automatic logic [31:0] largest_free_bytes();
    logic [31:0] most;
    int          i;
    most = '0;
    for (i = 0; i < tbl_count; i++) begin
      if (tbl_free[i] && tbl_bytes[i] > most) most = tbl_bytes[i];
    end
    return most;
  endfunction

  function automatic logic [31:0] table_pointer();
    int i;
    int tries;
    if (tbl_count == 0) return '0;
    i = $urandom_range(0, tbl_count - 1);
    // prefer a block in use so frees and reallocates hit live data
    for (tries = 0; tries < 4 && tbl_free[i]; tries++) i = $urandom_range(0, tbl_count - 1);
    return tbl_start[i] + HdrBytes;
  endfunction

  function automatic logic [31:0] stray_pointer();
    if ($urandom_range(0, 1) == 0) return $urandom;
    return table_pointer() + $urandom_range(1, HdrBytes - 1);
  endfunction

  function automatic logic [31:0] random_size();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 4) return '0;
    if (r < 10) return $urandom;
    if (r < 20) return $urandom_range(1, 4096);
    return $urandom_range(1, 256);
  endfunction

  task automatic send_request(input logic [1:0] cmd, input logic [31:0] size,
                              input logic [31:0] ptr, input bit pause, output grant_t grant);
    int unsigned gap;
    gap = $urandom_range(0, req_gap_max);
    if (pause && gap == 0) gap = 1;
    if (gap > 0) begin
      if (req_up) begin
        req_if.valid <= 1'b0;
        req_up = 1'b0;
      end
      while (pause && grants_due.size() != 0) @(posedge clk_i);
      repeat (gap) @(posedge clk_i);
    end
    req_if.valid        <= 1'b1;
    req_if.cmd          <= cmd;
    req_if.request_size <= size;
    req_if.user_pointer <= ptr;
    req_up = 1'b1;
    do @(posedge clk_i); while (!req_if.ready);
    grant = apply_request(cmd, size, ptr);
    grants_due.push_back(grant);
    request_count++;
  endtask

  task automatic wait_for_grants();
    if (req_up) begin
      req_if.valid <= 1'b0;
      req_up = 1'b0;
    end
    while (grants_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_heap_reg(input ffba_pkg::cfg_idx_e idx, input logic [31:0] value);
    wait_for_grants();
    repeat (4) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_idx   <= idx;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    if (idx == ffba_pkg::CFG_HEAP_BASE) begin
      heap_base = value;
      if (tbl_count == 0) heap_end = value;
    end else begin
      heap_limit = value;
    end
  endtask

  task automatic random_request(input int unsigned pause_pct);
    logic [1:0]  cmd;
    logic [31:0] size;
    logic [31:0] ptr;
    int unsigned r;
    int          owner;
    grant_t      grant;
    r    = $urandom_range(0, 99);
    size = random_size();
    ptr  = table_pointer();
    if (r < 38) begin
      cmd = ffba_pkg::CMD_ALLOC;
    end else if (r < 63) begin
      cmd = ffba_pkg::CMD_FREE;
    end else if (r < 95) begin
      cmd   = ffba_pkg::CMD_REALLOC;
      owner = owner_index(ptr);
      // shrink or grow around the current block size
      if (owner >= 0 && $urandom_range(0, 2) != 0) begin
        if ($urandom_range(0, 1) == 0) size = tbl_bytes[owner] >> $urandom_range(0, 2);
        else size = tbl_bytes[owner] + $urandom_range(1, 64);
      end
    end else begin
      cmd  = CmdUnused;
      size = $urandom;
      ptr  = $urandom;
    end
    if (cmd == ffba_pkg::CMD_FREE || cmd == ffba_pkg::CMD_REALLOC) begin
      r = $urandom_range(0, 9);
      if (r == 0) ptr = '0;
      else if (r == 1) ptr = stray_pointer();
    end
    send_request(cmd, size, ptr, $urandom_range(0, 99) < pause_pct, grant);
  endtask

  task automatic run_random(input int unsigned count, input int unsigned pause_pct);
    repeat (count) random_request(pause_pct);
  endtask

  task automatic test_directed();
    grant_t      g;
    logic [31:0] first_ptr;
    logic [31:0] second_ptr;
    // empty table at the top of the address space: every append overflows
    write_heap_reg(ffba_pkg::CFG_HEAP_BASE, '1);
    send_request(ffba_pkg::CMD_ALLOC, 32'd1, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_ALLOC, '0, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_FREE, '0, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_FREE, '0, '1, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, '0, 32'hDEAD_BEEF, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, 32'd5, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, 32'd5, 32'h0000_1234, 1'b0, g);
    send_request(CmdUnused, '1, '1, 1'b0, g);
    write_heap_reg(ffba_pkg::CFG_HEAP_LIMIT, '0);
    write_heap_reg(ffba_pkg::CFG_HEAP_BASE, '0);
    send_request(ffba_pkg::CMD_ALLOC, 32'd1, '0, 1'b0, g);
    write_heap_reg(ffba_pkg::CFG_HEAP_LIMIT, '1);
    write_heap_reg(ffba_pkg::CFG_HEAP_BASE, 32'h0000_1000);
    send_request(ffba_pkg::CMD_ALLOC, '1, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_ALLOC, 32'd100, '0, 1'b0, g);
    first_ptr = g.pointer;
    send_request(ffba_pkg::CMD_ALLOC, 32'd50, '0, 1'b0, g);
    second_ptr = g.pointer;
    send_request(ffba_pkg::CMD_REALLOC, 32'd80, first_ptr, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, 32'd200, first_ptr, 1'b0, g);
    send_request(ffba_pkg::CMD_ALLOC, 32'd60, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_FREE, '0, second_ptr, 1'b0, g);
    send_request(ffba_pkg::CMD_FREE, '0, second_ptr, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, 32'd10, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_FREE, '0, first_ptr + 32'd4, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, '1, first_ptr, 1'b0, g);
    send_request(ffba_pkg::CMD_ALLOC, 32'h8000_0000, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_ALLOC, 32'd1, '0, 1'b0, g);
  endtask

  task automatic test_heap_limit();
    write_heap_reg(ffba_pkg::CFG_HEAP_LIMIT, heap_end + $urandom_range(1500, 5000));
    run_random(120, 10);
    write_heap_reg(ffba_pkg::CFG_HEAP_LIMIT, '1);
  endtask

  task automatic test_table_full();
    grant_t      g;
    int unsigned tries;
    tries = 0;
    // grow past every free block so each request appends
    while (tbl_count < NumBlocks && tries < 2 * NumBlocks) begin
      send_request(ffba_pkg::CMD_ALLOC, largest_free_bytes() + $urandom_range(1, 32), '0,
                   $urandom_range(0, 3) == 0, g);
      tries++;
    end
    send_request(ffba_pkg::CMD_ALLOC, largest_free_bytes() + 32'd1, '0, 1'b0, g);
    // a full table wins over the heap limit
    write_heap_reg(ffba_pkg::CFG_HEAP_LIMIT, '0);
    send_request(ffba_pkg::CMD_ALLOC, largest_free_bytes() + 32'd1, '0, 1'b0, g);
    send_request(ffba_pkg::CMD_REALLOC, largest_free_bytes() + 32'd1, table_pointer(),
                 1'b0, g);
    write_heap_reg(ffba_pkg::CFG_HEAP_LIMIT, '1);
  endtask

  task automatic test_mixed_traffic();
    // table is not empty: only the register changes
    write_heap_reg(ffba_pkg::CFG_HEAP_BASE, '0);
    run_random(230, 15);
  endtask

  task automatic test_no_idle();
    req_gap_max   = 0;
    rsp_stall_max = 0;
    run_random(60, 0);
    req_gap_max   = 4;
    rsp_stall_max = 4;
  endtask

  task automatic test_result_backpressure();
    wait_for_grants();
    req_gap_max = 0;
    // hold results long enough that the request side backs up
    rsp_hold_cycles = 8 * ScanCycles;
    run_random(10, 0);
    req_gap_max = 4;
  endtask

  task automatic test_sender_pause();
    run_random(40, 100);
  endtask

  always @(posedge clk_i) begin
    grant_t want;
    if (rst_ni && rsp_if.valid && rsp_if.ready) begin
      if (grants_due.size() == 0) begin
        $error("unexpected result: result_pointer 0x%08h status %0d",
               rsp_if.result_pointer, rsp_if.status);
        fail_count++;
      end else begin
        want = grants_due.pop_front();
        if (rsp_if.result_pointer !== want.pointer) begin
          $error("result_pointer: expected 0x%08h, actual 0x%08h",
                 want.pointer, rsp_if.result_pointer);
          fail_count++;
        end
        if (rsp_if.status !== want.status) begin
          $error("status: expected %0d, actual %0d", want.status, rsp_if.status);
          fail_count++;
        end
        status_tally[want.status]++;
      end
    end
  end

  initial begin : result_receiver
    int unsigned stall_left;
    stall_left = 0;
    rsp_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (rsp_hold_cycles > 0) begin
        rsp_if.ready <= 1'b0;
        rsp_hold_cycles--;
      end else if (rsp_if.valid && rsp_if.ready) begin
        stall_left = $urandom_range(0, rsp_stall_max);
        if (stall_left > 0) rsp_if.ready <= 1'b0;
      end else if (!rsp_if.ready) begin
        // count the stall only while a result is offered
        if (stall_left == 0) rsp_if.ready <= 1'b1;
        else if (rsp_if.valid) stall_left--;
      end
    end
  end

  initial begin
    #4_000_000;
    $display("testbench NOT OK");
    $finish;
  end

  initial begin
    req_gap_max     = 4;
    rsp_stall_max   = 4;
    rsp_hold_cycles = 0;
    req_up          = 1'b0;
    fail_count      = 0;
    request_count   = 0;
    tbl_count       = 0;
    heap_base       = '0;
    heap_limit      = '1;
    heap_end        = '0;
    foreach (status_tally[i]) status_tally[i] = 0;
    cfg_we              <= 1'b0;
    cfg_idx             <= ffba_pkg::CFG_HEAP_BASE;
    cfg_wdata           <= '0;
    req_if.valid        <= 1'b0;
    req_if.cmd          <= ffba_pkg::CMD_ALLOC;
    req_if.request_size <= '0;
    req_if.user_pointer <= '0;
    rst_ni              <= 1'b0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_directed();
    test_heap_limit();
    test_table_full();
    test_mixed_traffic();
    test_no_idle();
    test_result_backpressure();
    test_sender_pause();

    wait_for_grants();
    repeat (3 * ScanCycles + 16) @(posedge clk_i);
    $display("covered %0d requests: %0d ok, %0d zero size, %0d heap limit,",
             request_count, status_tally[ffba_pkg::STAT_OK],
             status_tally[ffba_pkg::STAT_ZERO], status_tally[ffba_pkg::STAT_LIMIT]);
    $display("%0d table full, %0d unknown pointer; table ends with %0d of %0d blocks",
             status_tally[ffba_pkg::STAT_FULL], status_tally[ffba_pkg::STAT_UNKNOWN],
             tbl_count, NumBlocks);
    if (fail_count == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hdl/ffba_pkg.sv
hdl/ffba_req_if.sv
hdl/ffba_rsp_if.sv
hdl/ffba_cell.sv
hdl/first_fit_block_allocator.sv
verif/testbench.sv
